// ----- src/evc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder volume control package
// Shared types and constants for the encoder volume control block.
// ----------------------------------------------------------------------------
package evc_pkg;

  localparam int unsigned VolW  = 5;
  localparam int unsigned TickW = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_VOLUME_MAX    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 2'd2;

  // Reset values.
  localparam logic [VolW-1:0]  VOLUME_MAX_RST    = 5'd30;
  localparam logic [TickW-1:0] HOLD_TICKS_RST    = 12'd200;
  localparam logic [TickW-1:0] TIMEOUT_TICKS_RST = 12'd2000;
  localparam logic [VolW-1:0]  LEVEL_RST         = 5'd15;
  localparam logic [TickW-1:0] TICK_MAX          = 12'hFFF;

  typedef struct packed {
    logic [VolW-1:0]  volume_max;
    logic [TickW-1:0] hold_ticks;
    logic [TickW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [VolW-1:0]  volume;
    logic             volume_cmd;
    logic             adjusting;
    logic [TickW-1:0] adjust_count;
  } result_t;

endpackage

// ----- src/evc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder volume control configuration registers
// Holds the clamp limit, hold threshold and timeout written over the port.
// ----------------------------------------------------------------------------
module evc_cfg
  import evc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VOLUME_MAX:    cfg_d.volume_max    = cfg_data_i[VolW-1:0];
        REG_HOLD_TICKS:    cfg_d.hold_ticks    = cfg_data_i[TickW-1:0];
        REG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i[TickW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume_max    <= VOLUME_MAX_RST;
      cfg_q.hold_ticks    <= HOLD_TICKS_RST;
      cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/evc_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder volume control tick logic
// Decodes one pin sample, updates level and adjust-mode state, forms a result.
// ----------------------------------------------------------------------------
module evc_step
  import evc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    accept_i,
  input  logic    pin_a_i,
  input  logic    pin_b_i,
  output result_t result_o
);

  logic             turn_down_q, turn_down_d;
  logic             armed_q, armed_d;
  logic [VolW-1:0]  level_q, level_d;
  logic             mode_q, mode_d;
  logic [TickW-1:0] ticks_q, ticks_d;

  logic             detent;
  logic [VolW:0]    cand;
  logic [TickW:0]   hold_inc;
  logic [TickW-1:0] ticks_hold;
  logic [TickW-1:0] ticks_inc;
  logic             mode_set;

  always_comb begin
    turn_down_d = turn_down_q;
    armed_d     = armed_q;
    if (!pin_a_i && pin_b_i) begin
      turn_down_d = 1'b1;
      armed_d     = 1'b1;
    end else if (pin_a_i && !pin_b_i) begin
      turn_down_d = 1'b0;
      armed_d     = 1'b1;
    end

    detent = pin_a_i && pin_b_i && armed_q;
    if (detent) begin
      armed_d = 1'b0;
    end

    // Step the level; a step down from zero stays at zero.
    if (!detent) begin
      cand = {1'b0, level_q};
    end else if (turn_down_q) begin
      cand = (level_q == '0) ? '0 : {1'b0, level_q} - 1'b1;
    end else begin
      cand = {1'b0, level_q} + 1'b1;
    end
    level_d = (cand >= {1'b0, cfg_i.volume_max}) ? cfg_i.volume_max : cand[VolW-1:0];

    hold_inc   = {1'b0, cfg_i.hold_ticks} + 1'b1;
    ticks_hold = ticks_q;
    if (detent && (ticks_q > cfg_i.hold_ticks)) begin
      ticks_hold = hold_inc[TickW] ? TICK_MAX : hold_inc[TickW-1:0];
    end

    mode_set  = mode_q || detent;
    ticks_inc = (mode_set && (ticks_hold != TICK_MAX)) ? ticks_hold + 1'b1 : ticks_hold;

    if (ticks_inc >= cfg_i.timeout_ticks) begin
      mode_d  = 1'b0;
      ticks_d = '0;
    end else begin
      mode_d  = mode_set;
      ticks_d = ticks_inc;
    end

    result_o.volume       = level_d;
    result_o.volume_cmd   = detent;
    result_o.adjusting    = mode_d;
    result_o.adjust_count = ticks_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_down_q <= 1'b0;
      armed_q     <= 1'b0;
      level_q     <= LEVEL_RST;
      mode_q      <= 1'b0;
      ticks_q     <= '0;
    end else if (accept_i) begin
      turn_down_q <= turn_down_d;
      armed_q     <= armed_d;
      level_q     <= level_d;
      mode_q      <= mode_d;
      ticks_q     <= ticks_d;
    end
  end

  // The tick counter only runs inside adjust mode.
  a_ticks_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q |-> (ticks_q == '0))
    else $error("adjust counter nonzero outside adjust mode");

  // A completed detent disarms until the next half step.
  a_detent_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && detent) |=> !armed_q)
    else $error("detent left armed after firing");

  // A detent always enters adjust mode unless the timeout cleared it at once.
  a_cmd_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && detent) |=> (mode_q || (ticks_q == '0)))
    else $error("detent did not enter adjust mode");

endmodule

// ----- src/evc_outbuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder volume control output buffer
// Output register plus skid entry, so a new beat is taken while one waits.
// ----------------------------------------------------------------------------
module evc_outbuf
  import evc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  result_t in_data_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  output result_t out_data_o,
  input  logic    out_stall_i
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    take, acc;

  assign take = out_valid_q && !out_stall_i;
  assign acc  = in_valid_i && !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d = skid_q;
        if (acc) begin
          skid_d = in_data_i;
        end else begin
          skid_valid_d = 1'b0;
        end
      end else begin
        out_valid_d = acc;
        if (acc) begin
          out_d = in_data_i;
        end
      end
    end else if (!out_valid_q) begin
      if (acc) begin
        out_valid_d = 1'b1;
        out_d       = in_data_i;
      end
    end else if (acc) begin
      // Output beat is stalled: park the new beat in the skid entry.
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The skid entry only fills behind a held output beat.
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // A full buffer facing a stall stays full.
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> (skid_valid_q && out_valid_q))
    else $error("buffered beat lost under stall");

endmodule

// ----- src/encoder_volume_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder volume control
// Rotary-encoder volume stepping with clamp, command strobe and adjust timer.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat carries one sample of the two encoder pins (one tick).
//   Each accepted beat yields exactly one result beat: the clamped volume,
//   the command strobe, the adjust-mode flag and the adjust tick counter.
//   A beat is accepted when in_valid_i is high and in_stall_o is low; a
//   result is taken when out_valid_o is high and out_stall_i is low.
//   The result is registered: it goes into the output register, or into the
//   skid entry while the output beat is held. Throughput is one beat per
//   cycle while in_stall_o is low, set by the single pass of the tick logic.
//   When the receiver stalls, the output register holds its beat and one
//   more beat is parked in a skid entry; in_stall_o rises only when both
//   are full. Reset sets level 15, clears adjust mode and the counter and
//   loads the register defaults (max 30, hold 200, timeout 2000).
//   Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.
// ----------------------------------------------------------------------------
module encoder_volume_control
  import evc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                pin_a_i,
  input  logic                pin_b_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VolW-1:0]     volume_o,
  output logic                volume_cmd_o,
  output logic                adjusting_o,
  output logic [TickW-1:0]    adjust_count_o
);

  cfg_t    cfg;
  result_t step_res;
  result_t out_res;
  logic    accept;

  assign accept = in_valid_i && !in_stall_o;

  evc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  evc_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .pin_a_i  (pin_a_i),
    .pin_b_i  (pin_b_i),
    .result_o (step_res)
  );

  evc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (step_res),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .out_stall_i (out_stall_i)
  );

  assign volume_o       = out_res.volume;
  assign volume_cmd_o   = out_res.volume_cmd;
  assign adjusting_o    = out_res.adjusting;
  assign adjust_count_o = out_res.adjust_count;

endmodule
